/* rtl/q_learning_agent_top_macros.svh */
// Assertion macros for the Q-learning agent.
// Used by q_learning_agent_top; no other dependencies.
`ifndef Q_LEARNING_AGENT_TOP_MACROS_SVH
`define Q_LEARNING_AGENT_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define QLA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qla: same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define QLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qla: next-cycle check failed");
`else
`define QLA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define QLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/qla_pkg.sv */
// Shared constants, types and command/status structures of the Q-learning agent.
// No dependencies; the interfaces, top level, controller and datapath import this package.
package qla_pkg;

    // Table geometry and fixed-point format.
    localparam int STATES      = 16;
    localparam int ACTIONS     = 4;
    localparam int FRAC_BITS   = 16;

    localparam int STATE_W     = $clog2(STATES);
    localparam int ACTION_W    = $clog2(ACTIONS);
    localparam int CNT_W       = $clog2(ACTIONS + 1);
    localparam int TABLE_DEPTH = STATES * ACTIONS;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // Field widths of the item and result.
    localparam int Q_W         = 32;
    localparam int RATE_W      = 17;
    localparam int RAND_W      = 16;
    localparam int NSTATE_W    = 4;
    localparam int REWARD_W    = 8;

    // Configuration port.
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = RATE_W;

    localparam logic [RATE_W-1:0] LEARN_RATE_RST   = RATE_W'(6554);
    localparam logic [RATE_W-1:0] DISCOUNT_RST     = RATE_W'(58982);
    localparam logic [RATE_W-1:0] EXPLORE_RATE_RST = RATE_W'(6554);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARN_RATE,
        CFG_DISCOUNT,
        CFG_EXPLORE_RATE,
        CFG_GREEDY_ONLY
    } t_cfg_idx;

    // Item kinds.
    localparam logic KIND_CHOOSE = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK,
        ST_SCAN_TIE,
        ST_DRAIN_TIE,
        ST_READ_QCUR,
        ST_MUL_DISC,
        ST_TD,
        ST_MUL_LEARN,
        ST_SUM,
        ST_COMMIT
    } t_qla_state;

    // Which table row a read goes to.
    typedef enum logic [1:0] {
        SRC_CUR_ROW,
        SRC_NEXT_ROW,
        SRC_PENDING
    } t_rd_src;

    // What the datapath does with the read data in the cycle after the read.
    typedef enum logic [1:0] {
        TAG_NONE,
        TAG_MAX,
        TAG_TIE,
        TAG_QCUR
    } t_rd_tag;

    // Datapath steps that do not touch the table read port.
    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_PICK,
        STEP_MUL_DISC,
        STEP_TD,
        STEP_MUL_LEARN,
        STEP_SUM,
        STEP_COMMIT
    } t_step;

    typedef struct packed {
        logic                load;
        t_rd_src             rd_src;
        logic [ACTION_W-1:0] rd_col;
        t_rd_tag             rd_tag;
        t_step               step;
    } t_qla_cmd;

    typedef struct packed {
        logic is_update;
        logic explore;
        logic out_busy;
    } t_qla_sts;

    typedef struct packed {
        logic                       kind;
        logic [RAND_W-1:0]          rand_decide;
        logic [RAND_W-1:0]          rand_pick;
        logic [NSTATE_W-1:0]        next_state;
        logic signed [REWARD_W-1:0] reward;
        logic                       episode_end;
    } t_qla_item;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic                  explored;
        logic signed [Q_W-1:0] q_new;
        logic [STATE_W-1:0]    state_index;
    } t_qla_result;

endpackage

/* rtl/qla_if.sv */
// Valid/ready channel interfaces for the agent's input items and results.
// Depends on qla_pkg for the field widths.
interface qla_item_if import qla_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [RAND_W-1:0]          rand_decide;
    logic [RAND_W-1:0]          rand_pick;
    logic [NSTATE_W-1:0]        next_state;
    logic signed [REWARD_W-1:0] reward;
    logic                       episode_end;

    modport source (
        output valid, kind, rand_decide, rand_pick, next_state, reward, episode_end,
        input  ready
    );
    modport sink (
        input  valid, kind, rand_decide, rand_pick, next_state, reward, episode_end,
        output ready
    );
endinterface

interface qla_result_if import qla_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic                  explored;
    logic signed [Q_W-1:0] q_new;
    logic [STATE_W-1:0]    state_index;

    modport source (
        output valid, action, explored, q_new, state_index,
        input  ready
    );
    modport sink (
        input  valid, action, explored, q_new, state_index,
        output ready
    );
endinterface

/* rtl/q_learning_agent_top.sv */
// Top level of the fixed-point tabular Q-learning agent with epsilon-greedy choice.
// Depends on qla_pkg, qla_if, qla_ctrl, qla_dpath and the assertion macro header.
//
//  Channel   Direction  Handshake        Contents
//  i_item    in         valid/ready      kind, random fractions, next state, reward, end
//  o_result  out        valid/ready      action, explored, q_new, state_index
//  i_cfg_*   in         write enable     register index and data, no read-back
//
// A choose item scans its row for the maximum and then picks; when it exploits it scans the
// row again to find the chosen tie, and when it explores it goes straight to the commit.
// An update item scans the next row, reads the current entry and runs the two multiplications,
// each registered, before its commit. The single table read port scans a row one entry a cycle.
// Reset is synchronous; table entries are marked invalid at once and read as zero.
// A result waits in the output register; a new item is accepted meanwhile, and only the
// commit of the following result waits for the register to drain.
`include "q_learning_agent_top_macros.svh"
module q_learning_agent_top import qla_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    qla_item_if.sink              i_item,
    qla_result_if.source          o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_qla_cmd    w_cmd;
    t_qla_sts    w_sts;
    t_qla_item   w_item;
    t_qla_result w_result;
    logic        w_in_ready;
    logic        w_out_valid;

    // Gather the item fields for the datapath.
    assign w_item.kind        = i_item.kind;
    assign w_item.rand_decide = i_item.rand_decide;
    assign w_item.rand_pick   = i_item.rand_pick;
    assign w_item.next_state  = i_item.next_state;
    assign w_item.reward      = i_item.reward;
    assign w_item.episode_end = i_item.episode_end;
    assign i_item.ready       = w_in_ready;

    // Drive the result channel.
    assign o_result.valid       = w_out_valid;
    assign o_result.action      = w_result.action;
    assign o_result.explored    = w_result.explored;
    assign o_result.q_new       = w_result.q_new;
    assign o_result.state_index = w_result.state_index;

    // Sequencer.
    qla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // Table, arithmetic and result register.
    qla_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_result.ready),
        .o_result    (w_result)
    );

    // A result is committed only into a free or draining output register.
    `QLA_ASSERT_IMPL(a_commit_free, i_clk, i_rst_n, w_cmd.step == STEP_COMMIT, !(o_result.valid && !o_result.ready))
    // A result is committed in the cycle before it appears.
    `QLA_ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, w_cmd.step == STEP_COMMIT, o_result.valid)
    // The block never accepts two items in consecutive cycles.
    `QLA_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_item.valid && i_item.ready, !i_item.ready)
    // Output valid rises only after a commit.
    `QLA_ASSERT_IMPL(a_rise_from_commit, i_clk, i_rst_n, $rose(o_result.valid), $past(w_cmd.step == STEP_COMMIT))

endmodule

/* rtl/qla_ctrl.sv */
// Controller state machine of the Q-learning agent: sequences table scans,
// the action pick, the update arithmetic and the commit. Depends on qla_pkg.
module qla_ctrl import qla_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output t_qla_cmd o_cmd,
    input  t_qla_sts i_sts
);

    t_qla_state          r_state, n_state;
    logic [ACTION_W-1:0] r_col, n_col;
    logic                col_last;

    assign col_last = (r_col == ACTION_W'(ACTIONS - 1));

    // State and column counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
        end
    end

    // Column counter runs only while a row is being scanned.
    always_comb begin
        if (r_state == ST_SCAN || r_state == ST_SCAN_TIE) begin
            n_col = r_col + ACTION_W'(1);
        end else begin
            n_col = '0;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (col_last) begin
                    n_state = i_sts.is_update ? ST_READ_QCUR : ST_DRAIN;
                end
            end
            ST_DRAIN:     n_state = ST_PICK;
            ST_PICK:      n_state = i_sts.explore ? ST_COMMIT : ST_SCAN_TIE;
            ST_SCAN_TIE: begin
                if (col_last) begin
                    n_state = ST_DRAIN_TIE;
                end
            end
            ST_DRAIN_TIE: n_state = ST_COMMIT;
            ST_READ_QCUR: n_state = ST_MUL_DISC;
            ST_MUL_DISC:  n_state = ST_TD;
            ST_TD:        n_state = ST_MUL_LEARN;
            ST_MUL_LEARN: n_state = ST_SUM;
            ST_SUM:       n_state = ST_COMMIT;
            ST_COMMIT: begin
                if (!i_sts.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.rd_src  = SRC_CUR_ROW;
        o_cmd.rd_col  = r_col;
        o_cmd.rd_tag  = TAG_NONE;
        o_cmd.step    = STEP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.rd_src = i_sts.is_update ? SRC_NEXT_ROW : SRC_CUR_ROW;
                o_cmd.rd_tag = TAG_MAX;
            end
            ST_PICK:      o_cmd.step = STEP_PICK;
            ST_SCAN_TIE: begin
                o_cmd.rd_src = SRC_CUR_ROW;
                o_cmd.rd_tag = TAG_TIE;
            end
            ST_READ_QCUR: begin
                o_cmd.rd_src = SRC_PENDING;
                o_cmd.rd_tag = TAG_QCUR;
            end
            ST_MUL_DISC:  o_cmd.step = STEP_MUL_DISC;
            ST_TD:        o_cmd.step = STEP_TD;
            ST_MUL_LEARN: o_cmd.step = STEP_MUL_LEARN;
            ST_SUM:       o_cmd.step = STEP_SUM;
            ST_COMMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.step = STEP_COMMIT;
                end
            end
            default: begin
                o_cmd.step = STEP_NONE;
            end
        endcase
    end

endmodule

/* rtl/qla_dpath.sv */
// Datapath of the Q-learning agent: configuration registers, the Q table
// with its read port, row maximum and tie logic, update arithmetic and the
// result register. Depends on qla_pkg.
module qla_dpath import qla_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_qla_item             i_item,
    input  t_qla_cmd              i_cmd,
    output t_qla_sts              o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_qla_result           o_result
);

    // Widths of the update arithmetic.
    localparam int PD_W   = Q_W + RATE_W + 1;
    localparam int DISC_W = PD_W - FRAC_BITS;
    localparam int RFX_W  = REWARD_W + FRAC_BITS;
    localparam int TD_W   = ((DISC_W > RFX_W) ? DISC_W : RFX_W) + 2;
    localparam int PL_W   = TD_W + RATE_W + 1;
    localparam int DL_W   = PL_W - FRAC_BITS;
    localparam int SUM_W  = ((DL_W > Q_W) ? DL_W : Q_W) + 1;
    localparam int PP_W   = RAND_W + CNT_W;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W - 1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W - 1){1'b0}}};

    // Configuration.
    logic [RATE_W-1:0] r_learn_rate;
    logic [RATE_W-1:0] r_discount;
    logic [RATE_W-1:0] r_explore_rate;
    logic              r_greedy_only;

    // Captured item.
    logic                       r_kind;
    logic [RAND_W-1:0]          r_rand_decide;
    logic [RAND_W-1:0]          r_rand_pick;
    logic [STATE_W-1:0]         r_next_row;
    logic signed [REWARD_W-1:0] r_reward;
    logic                       r_episode_end;

    // Agent state.
    logic [STATE_W-1:0]  r_cur_state;
    logic [ACTION_W-1:0] r_pending;

    // Q table and its registered read port.
    logic [Q_W-1:0]         r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [Q_W-1:0]         r_rd_data;
    logic                   r_rd_valid;
    t_rd_tag                r_tag;
    logic [ACTION_W-1:0]    r_col;

    // Working registers.
    logic signed [Q_W-1:0]  r_max;
    logic [CNT_W-1:0]       r_ties;
    logic [CNT_W-1:0]       r_pick;
    logic [ACTION_W-1:0]    r_act;
    logic                   r_found;
    logic                   r_explored;
    logic signed [Q_W-1:0]  r_qcur;
    logic signed [PD_W-1:0] r_prod_disc;
    logic signed [TD_W-1:0] r_td;
    logic signed [PL_W-1:0] r_prod_learn;
    logic signed [Q_W-1:0]  r_result;

    // Result register.
    logic        r_out_valid;
    t_qla_result r_out;

    logic [STATE_W-1:0]       rd_row;
    logic [ACTION_W-1:0]      rd_col;
    logic [ADDR_W-1:0]        rd_addr;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [Q_W-1:0]    rd_q;
    logic                     explore;
    logic [CNT_W-1:0]         pick_base;
    logic [PP_W-1:0]          pick_prod;
    logic [PP_W-1:0]          pick_sh;
    logic [CNT_W-1:0]         pick_lim;
    logic [CNT_W-1:0]         pick_val;
    logic signed [RATE_W:0]   disc_op;
    logic signed [RATE_W:0]   learn_op;
    logic signed [DISC_W-1:0] disc_sh;
    logic signed [TD_W-1:0]   reward_fx;
    logic signed [DL_W-1:0]   delta;
    logic signed [SUM_W-1:0]  sum;
    logic signed [Q_W-1:0]    sum_sat;
    logic [STATE_W-1:0]       state_after;
    logic                     commit;

    assign commit = (i_cmd.step == STEP_COMMIT);

    // Read address: the scanned row, or the pending entry of the current row.
    always_comb begin
        unique case (i_cmd.rd_src)
            SRC_CUR_ROW: begin
                rd_row = r_cur_state;
                rd_col = i_cmd.rd_col;
            end
            SRC_NEXT_ROW: begin
                rd_row = r_next_row;
                rd_col = i_cmd.rd_col;
            end
            SRC_PENDING: begin
                rd_row = r_cur_state;
                rd_col = r_pending;
            end
            default: begin
                rd_row = r_cur_state;
                rd_col = i_cmd.rd_col;
            end
        endcase
    end

    assign rd_addr = ADDR_W'(rd_row) * ADDR_W'(ACTIONS) + ADDR_W'(rd_col);
    assign wr_addr = ADDR_W'(r_cur_state) * ADDR_W'(ACTIONS) + ADDR_W'(r_pending);

    // An entry never written since reset reads as zero.
    assign rd_q = r_rd_valid ? signed'(r_rd_data) : '0;

    // Exploration decision and the pick among ACTIONS or among the ties.
    assign explore   = !r_greedy_only && (RATE_W'(r_rand_decide) < r_explore_rate);
    assign pick_base = explore ? CNT_W'(ACTIONS) : r_ties;
    assign pick_prod = PP_W'(r_rand_pick) * PP_W'(pick_base);
    assign pick_sh   = pick_prod >> FRAC_BITS;
    assign pick_lim  = pick_base - CNT_W'(1);
    assign pick_val  = (pick_sh > PP_W'(pick_lim)) ? pick_lim : CNT_W'(pick_sh);

    // Update arithmetic operands.
    assign disc_op   = signed'({1'b0, r_discount});
    assign learn_op  = signed'({1'b0, r_learn_rate});
    assign disc_sh   = DISC_W'(r_prod_disc >>> FRAC_BITS);
    assign reward_fx = TD_W'(r_reward) <<< FRAC_BITS;
    assign delta     = DL_W'(r_prod_learn >>> FRAC_BITS);
    assign sum       = SUM_W'(r_qcur) + SUM_W'(delta);

    // Saturate the new value to the signed table range.
    always_comb begin
        if (sum > SUM_W'(Q_MAX)) begin
            sum_sat = Q_MAX;
        end else if (sum < SUM_W'(Q_MIN)) begin
            sum_sat = Q_MIN;
        end else begin
            sum_sat = Q_W'(sum);
        end
    end

    assign state_after = r_episode_end ? '0 : r_next_row;

    // Control state: configuration, agent state, valid bits, result handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_rate   <= LEARN_RATE_RST;
            r_discount     <= DISCOUNT_RST;
            r_explore_rate <= EXPLORE_RATE_RST;
            r_greedy_only  <= 1'b0;
            r_cur_state    <= '0;
            r_pending      <= '0;
            r_valid        <= '0;
            r_tag          <= TAG_NONE;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_LEARN_RATE:   r_learn_rate   <= i_cfg_data;
                    CFG_DISCOUNT:     r_discount     <= i_cfg_data;
                    CFG_EXPLORE_RATE: r_explore_rate <= i_cfg_data;
                    CFG_GREEDY_ONLY:  r_greedy_only  <= i_cfg_data[0];
                endcase
            end
            r_tag <= i_cmd.rd_tag;
            if (commit) begin
                if (r_kind == KIND_UPDATE) begin
                    r_cur_state <= state_after;
                    if (!r_greedy_only) begin
                        r_valid[wr_addr] <= 1'b1;
                    end
                end else begin
                    r_pending <= r_act;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Table write and registered read.
    always_ff @(posedge i_clk) begin
        if (commit && r_kind == KIND_UPDATE && !r_greedy_only) begin
            r_mem[wr_addr] <= r_result;
        end
        r_rd_data  <= r_mem[rd_addr];
        r_rd_valid <= r_valid[rd_addr];
        r_col      <= rd_col;
    end

    // Item capture, scan processing, arithmetic steps and the result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind        <= i_item.kind;
            r_rand_decide <= i_item.rand_decide;
            r_rand_pick   <= i_item.rand_pick;
            r_next_row    <= STATE_W'(i_item.next_state % STATES);
            r_reward      <= i_item.reward;
            r_episode_end <= i_item.episode_end;
        end

        // Read data arrives in the cycle after its address.
        unique case (r_tag)
            TAG_MAX: begin
                if (r_col == '0 || rd_q > r_max) begin
                    r_max  <= rd_q;
                    r_ties <= CNT_W'(1);
                end else if (rd_q == r_max) begin
                    r_ties <= r_ties + CNT_W'(1);
                end
            end
            TAG_TIE: begin
                if (rd_q == r_max && !r_found) begin
                    if (r_pick == '0) begin
                        r_act   <= r_col;
                        r_found <= 1'b1;
                    end else begin
                        r_pick <= r_pick - CNT_W'(1);
                    end
                end
            end
            TAG_QCUR: r_qcur <= rd_q;
            TAG_NONE: begin
            end
        endcase

        unique case (i_cmd.step)
            STEP_PICK: begin
                r_pick     <= pick_val;
                r_explored <= explore;
                r_found    <= 1'b0;
                r_act      <= explore ? ACTION_W'(pick_val) : '0;
            end
            STEP_MUL_DISC:  r_prod_disc  <= r_max * disc_op;
            STEP_TD:        r_td         <= reward_fx + TD_W'(disc_sh) - TD_W'(r_qcur);
            STEP_MUL_LEARN: r_prod_learn <= r_td * learn_op;
            STEP_SUM:       r_result     <= sum_sat;
            STEP_COMMIT: begin
                if (r_kind == KIND_UPDATE) begin
                    r_out.action      <= r_pending;
                    r_out.explored    <= 1'b0;
                    r_out.q_new       <= r_result;
                    r_out.state_index <= state_after;
                end else begin
                    r_out.action      <= r_act;
                    r_out.explored    <= r_explored;
                    r_out.q_new       <= r_max;
                    r_out.state_index <= r_cur_state;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_sts.is_update = (r_kind == KIND_UPDATE);
    assign o_sts.explore   = explore;
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_result        = r_out;

endmodule
